>>> hdl/dwr_pkg.sv
// Shared types and constants for the double-ended queue with reverse.
package dwr_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int KIND_W        = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_REVERSE    = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_POP_BACK   = 3'd4,
        KIND_DUMP       = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

endpackage

>>> hdl/deque_with_reverse_core.sv
// Top level: ring-store double-ended queue with order reversal and dump.
//
//  channel | dir | tdata             | tuser                          | tlast
//  s_      | in  | value[31:0]       | kind[2:0]                      | -
//  m_      | out | data[31:0]        | [0] empty_error [1] full_error | last
//
// Push, reverse, unknown kinds and empty pops/dumps are answered from the idle state.
// A pop passes through ST_POP, as the element store answers with a registered read.
// A dump alternates ST_DUMP_RD and ST_DUMP_OUT, one store read per element.
// A result sits in the output register; a new request is taken once it leaves.
// Reset empties the queue and clears the reversal flag; the store is not cleared.
module deque_with_reverse_core
    import dwr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // value[31:0]
    input  logic [KIND_W-1:0] s_tuser,   // kind[2:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // data[31:0]
    output logic [1:0]        m_tuser,   // empty_error[0], full_error[1]
    output logic              m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;
    logic [IDX_W-1:0]  dump_ptr_reg, dump_ptr_next;
    logic [CNT_W-1:0]  dump_left_reg, dump_left_next;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_empty_reg, m_empty_next;
    logic              m_full_reg, m_full_next;
    logic              m_last_reg, m_last_next;

    logic              accept;
    kind_t             kind;
    logic              is_full, is_empty;
    logic [SUM_W-1:0]  tail_sum, back_sum;
    logic [IDX_W-1:0]  tail_slot, back_slot;
    logic [IDX_W-1:0]  front_prev, front_succ;
    logic [IDX_W-1:0]  ptr_prev, ptr_succ;
    logic              push_phys_front, pop_phys_front;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;

    assign kind     = kind_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // ring arithmetic: tail_sum stays below twice the depth, back_sum too when not empty
    assign tail_sum   = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_sum   = tail_sum - SUM_W'(1);
    assign tail_slot  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                    : IDX_W'(tail_sum);
    assign back_slot  = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                    : IDX_W'(back_sum);
    assign front_prev = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - IDX_W'(1);
    assign front_succ = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);
    assign ptr_prev   = (dump_ptr_reg == '0) ? IDX_W'(DEPTH - 1)
                                             : dump_ptr_reg - IDX_W'(1);
    assign ptr_succ   = (dump_ptr_reg == IDX_W'(DEPTH - 1)) ? '0
                                                            : dump_ptr_reg + IDX_W'(1);

    // map logical ends onto the ring according to the reversal flag
    assign push_phys_front = (kind == KIND_PUSH_FRONT) ^ rev_reg;
    assign pop_phys_front  = (kind == KIND_POP_FRONT) ^ rev_reg;

    // handshake and store access
    always_comb begin
        s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
        mem_we    = 1'b0;
        mem_waddr = push_phys_front ? front_prev : tail_slot;
        mem_re    = 1'b0;
        mem_raddr = pop_phys_front ? front_reg : back_slot;
        if (state_reg == ST_DUMP_RD) begin
            mem_re    = 1'b1;
            mem_raddr = dump_ptr_reg;
        end else if (accept) begin
            if ((kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) && !is_full) begin
                mem_we = 1'b1;
            end
            if ((kind == KIND_POP_FRONT || kind == KIND_POP_BACK) && !is_empty) begin
                mem_re = 1'b1;
            end
        end
    end

    // next state and queue bookkeeping
    always_comb begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        dump_ptr_next  = dump_ptr_reg;
        dump_left_next = dump_left_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_empty_next   = m_empty_reg;
        m_full_next    = m_full_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_empty_next = 1'b0;
                    m_full_next  = 1'b0;
                    m_last_next  = 1'b1;
                    unique case (kind)
                        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                            if (is_full) begin
                                m_full_next = 1'b1;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                if (push_phys_front) begin
                                    front_next = front_prev;
                                end
                            end
                        end
                        KIND_REVERSE: begin
                            rev_next = !rev_reg;
                        end
                        KIND_POP_FRONT, KIND_POP_BACK: begin
                            if (is_empty) begin
                                m_empty_next = 1'b1;
                            end else begin
                                // result follows once the store answers
                                m_valid_next = 1'b0;
                                count_next   = count_reg - CNT_W'(1);
                                if (pop_phys_front) begin
                                    front_next = front_succ;
                                end
                                state_next = ST_POP;
                            end
                        end
                        KIND_DUMP: begin
                            if (is_empty) begin
                                m_empty_next = 1'b1;
                            end else begin
                                m_valid_next   = 1'b0;
                                dump_ptr_next  = rev_reg ? back_slot : front_reg;
                                dump_left_next = count_reg;
                                state_next     = ST_DUMP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                m_valid_next = 1'b1;
                m_data_next  = rd_data_reg;
                m_empty_next = 1'b0;
                m_full_next  = 1'b0;
                m_last_next  = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_DUMP_RD: begin
                dump_ptr_next = rev_reg ? ptr_prev : ptr_succ;
                state_next    = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                // hold the read data until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = rd_data_reg;
                    m_empty_next   = 1'b0;
                    m_full_next    = 1'b0;
                    m_last_next    = (dump_left_reg == CNT_W'(1));
                    dump_left_next = dump_left_reg - CNT_W'(1);
                    state_next     = (dump_left_reg == CNT_W'(1)) ? ST_IDLE : ST_DUMP_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= s_tdata;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            rev_reg     <= rev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_ptr_reg  <= dump_ptr_next;
        dump_left_reg <= dump_left_next;
        m_data_reg    <= m_data_next;
        m_empty_reg   <= m_empty_next;
        m_full_reg    <= m_full_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_full_reg, m_empty_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the double-ended queue with reverse and dump.
`timescale 1ns / 1ps

module testbench;
    import dwr_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_PER_PHASE = 68;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 4000;

    // kinds outside the enum: the block answers them as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              empty_err;
        logic              full_err;
        logic              last;
    } deque_result_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        bit                typed;
        deque_result_t     res;
    } request_row_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    // travels alongside the request so a typed row can replace the prediction
    bit                row_typed  = 1'b0;
    deque_result_t     row_result = '0;

    // predictor state
    logic [DATA_W-1:0] ring_copy [DEPTH];
    int                head_slot     = 0;
    int                fill_count    = 0;
    bit                order_flipped = 1'b0;

    deque_result_t     awaited_results [$];
    int                mismatch_count = 0;
    int                send_idle_pct  = 18;
    int                recv_idle_pct  = 54;
    bit                hold_request   = 1'b0;

    request_row_t      directed_rows [DIRECTED_ROWS];

    deque_with_reverse_core #(.DEPTH(DEPTH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic deque_result_t deque_outcome(input logic [DATA_W-1:0] data,
                                                    input logic emp, input logic full,
                                                    input logic last);
        deque_result_t r;
        r.data      = data;
        r.empty_err = emp;
        r.full_err  = full;
        r.last      = last;
        return r;
    endfunction

    function automatic request_row_t make_row(input logic [KIND_W-1:0] kind,
                                              input logic [DATA_W-1:0] value,
                                              input bit typed, input logic [DATA_W-1:0] data,
                                              input logic emp, input logic full);
        request_row_t row;
        row.kind  = kind;
        row.value = value;
        row.typed = typed;
        row.res   = deque_outcome(data, emp, full, 1'b1);
        return row;
    endfunction

    // Apply one request to the predictor and queue the results it causes.
    task automatic deque_apply(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
        int slot;
        int n;
        bit at_head;
        case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                at_head = (kind == KIND_PUSH_FRONT) ^ order_flipped;
                if (fill_count >= DEPTH) begin
                    awaited_results.push_back(deque_outcome('0, 1'b0, 1'b1, 1'b1));
                end else begin
                    if (at_head) begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        ring_copy[head_slot] = value;
                    end else begin
                        ring_copy[(head_slot + fill_count) % DEPTH] = value;
                    end
                    fill_count++;
                    awaited_results.push_back(deque_outcome('0, 1'b0, 1'b0, 1'b1));
                end
            end
            KIND_REVERSE: begin
                order_flipped = ~order_flipped;
                awaited_results.push_back(deque_outcome('0, 1'b0, 1'b0, 1'b1));
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                at_head = (kind == KIND_POP_FRONT) ^ order_flipped;
                if (fill_count == 0) begin
                    awaited_results.push_back(deque_outcome('0, 1'b1, 1'b0, 1'b1));
                end else begin
                    if (at_head) begin
                        slot      = head_slot;
                        head_slot = (head_slot + 1) % DEPTH;
                    end else begin
                        slot = (head_slot + fill_count - 1) % DEPTH;
                    end
                    fill_count--;
                    awaited_results.push_back(deque_outcome(ring_copy[slot], 1'b0, 1'b0, 1'b1));
                end
            end
            KIND_DUMP: begin
                if (fill_count == 0) begin
                    awaited_results.push_back(deque_outcome('0, 1'b1, 1'b0, 1'b1));
                end else begin
                    slot = order_flipped ? (head_slot + fill_count - 1) % DEPTH : head_slot;
                    for (n = 0; n < fill_count; n++) begin
                        awaited_results.push_back(deque_outcome(ring_copy[slot], 1'b0, 1'b0,
                                                                n == fill_count - 1));
                        slot = order_flipped ? (slot + DEPTH - 1) % DEPTH : (slot + 1) % DEPTH;
                    end
                end
            end
            default: begin
                awaited_results.push_back(deque_outcome('0, 1'b0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // Check results first, then predict for a request taken at the same edge.
    always @(posedge aclk) begin : result_check
        deque_result_t seen;
        deque_result_t want;
        int before_count;
        if (aresetn && m_tvalid && m_tready) begin
            seen = deque_outcome(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: expected nothing, got data=%h empty=%b full=%b last=%b",
                         $time, seen.data, seen.empty_err, seen.full_err, seen.last);
            end else begin
                want = awaited_results.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    $display({"%0t: expected data=%h empty=%b full=%b last=%b,",
                              " got data=%h empty=%b full=%b last=%b"},
                             $time, want.data, want.empty_err, want.full_err, want.last,
                             seen.data, seen.empty_err, seen.full_err, seen.last);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            before_count = awaited_results.size();
            deque_apply(s_tuser, s_tdata);
            if (row_typed) begin
                while (awaited_results.size() > before_count)
                    void'(awaited_results.pop_back());
                awaited_results.push_back(row_result);
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    initial begin : receiver
        int hold_left;
        bit hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input request_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= row.kind;
        s_tdata    <= row.value;
        row_typed  <= row.typed;
        row_result <= row.res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        request_row_t row;
        int phase;
        int n;
        int roll;
        bit filling;

        directed_rows = '{
            make_row(KIND_POP_FRONT,  32'h0000_0000, 1'b1, '0, 1'b1, 1'b0),
            make_row(KIND_POP_BACK,   32'hFFFF_FFFF, 1'b1, '0, 1'b1, 1'b0),
            make_row(KIND_DUMP,       32'h0000_0000, 1'b1, '0, 1'b1, 1'b0),
            make_row(KIND_REVERSE,    32'h1234_5678, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_SPARE_LO,   32'hFFFF_FFFF, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_SPARE_HI,   32'h8000_0000, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_PUSH_FRONT, 32'h8000_0000, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_PUSH_BACK,  32'h0000_0000, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_DUMP,       32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_REVERSE,    32'h0000_0000, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_DUMP,       32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_POP_FRONT,  32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_POP_BACK,   32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_PUSH_BACK,  32'h5555_5555, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_REVERSE,    32'h0000_0000, 1'b1, '0, 1'b0, 1'b0),
            make_row(KIND_DUMP,       32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_POP_BACK,   32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_POP_FRONT,  32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_POP_FRONT,  32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_POP_BACK,   32'h0000_0000, 1'b0, '0, 1'b0, 1'b0),
            make_row(KIND_POP_BACK,   32'h0000_0000, 1'b1, '0, 1'b1, 1'b0),
            make_row(KIND_DUMP,       32'h0000_0000, 1'b1, '0, 1'b1, 1'b0)
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // Random part: fill to overflow, then drain past empty, and so on.
        filling = 1'b1;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (filling && fill_count >= DEPTH && $urandom_range(3) == 0)
                    filling = 1'b0;
                else if (!filling && fill_count == 0 && $urandom_range(2) == 0)
                    filling = 1'b1;
                roll = $urandom_range(99);
                if (roll < 6)
                    row.kind = KIND_DUMP;
                else if (roll < 11)
                    row.kind = KIND_REVERSE;
                else if (roll < 13)
                    row.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
                else if (roll < (filling ? 88 : 28))
                    row.kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
                else
                    row.kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
                row.value = $urandom();
                row.typed = 1'b0;
                row.res   = '0;
                send_request(row);
            end
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/dwr_pkg.sv
hdl/deque_with_reverse_core.sv
sim/testbench.sv
